// ===== src/write_back_record_cache_assert.svh =====
// Assertion macros for the record cache.
`ifndef WRITE_BACK_RECORD_CACHE_ASSERT_SVH
`define WRITE_BACK_RECORD_CACHE_ASSERT_SVH
`ifndef SYNTHESIS
`define WBRC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define WBRC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define WBRC_ASSERT(lbl, prop, msg)
`define WBRC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== src/wbrc_pkg.sv =====
package wbrc_pkg;
    localparam int unsigned MAX_ENTRIES_DEF = 16;
    localparam int unsigned RECORD_BITS_DEF = 64;
    localparam int unsigned KEY_BITS        = 32;
    localparam int unsigned CAP_BITS        = 5;
    localparam int unsigned CAP_MIN         = 2;
    localparam int unsigned CAP_RESET       = 16;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_FILL  = 2'd2,
        KIND_FLUSH = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_READOUT,
        ST_DROP,
        ST_EVICT,
        ST_APPEND,
        ST_FLUSH,
        ST_EMPTY
    } t_state;

    typedef struct packed {
        logic accept;
        logic search;
        logic drop_hit;
        logic drop_head;
        logic append;
        logic emit_read;
        logic emit_wb;
        logic emit_empty;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  hit;
        logic  need_evict;
        logic  head_dirty;
        logic  empty;
        logic  sent;
        logic  out_free;
    } t_dp_sts;
endpackage

// ===== src/write_back_record_cache.sv =====
// Write-back record cache, fully associative, oldest entry replaced first.
// Input channel: i_valid / o_stall with i_kind, i_record_number, i_record_data;
// a transfer takes place when i_valid is high and o_stall is low. One item is
// handled at a time; o_stall stays high until all its results are produced.
// Output channel: o_valid / i_stall; each result is one transfer and o_last
// marks the final result of an item. A stalled result holds its fields.
// Configuration: i_cfg_valid / o_cfg_ready writes the capacity register.
// A read searches the entries and its result is registered. A write first drops
// any matching entry; a fill or write then evicts from the head while the cache
// is full, writing back each dirty evicted record, and appends the new record.
// A flush writes back every dirty entry and empties the cache. A fill, write or
// flush that writes nothing back gives a single result with no data. Eviction and
// flush shift the entry registers by one slot per cycle, but a dirty entry waits
// in place while the output is stalled.
// Reset (synchronous, active low) empties the cache, clears the highest
// written record number, drops any pending result and sets capacity to 16.
module write_back_record_cache
    import wbrc_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int unsigned RECORD_BITS = RECORD_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_kind,
    input  logic [KEY_BITS-1:0]    i_record_number,
    input  logic [RECORD_BITS-1:0] i_record_data,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_hit,
    output logic [RECORD_BITS-1:0] o_read_data,
    output logic                   o_writeback_valid,
    output logic [KEY_BITS-1:0]    o_writeback_number,
    output logic [RECORD_BITS-1:0] o_writeback_data,
    output logic [KEY_BITS-1:0]    o_highest_written,
    output logic                   o_last,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CAP_BITS-1:0]    i_cfg_data
);
`include "write_back_record_cache_assert.svh"

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    wbrc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    wbrc_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .RECORD_BITS (RECORD_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_valid        (i_cfg_valid & o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .i_kind             (i_kind),
        .i_record_number    (i_record_number),
        .i_record_data      (i_record_data),
        .i_stall            (i_stall),
        .o_valid            (o_valid),
        .o_hit              (o_hit),
        .o_read_data        (o_read_data),
        .o_writeback_valid  (o_writeback_valid),
        .o_writeback_number (o_writeback_number),
        .o_writeback_data   (o_writeback_data),
        .o_highest_written  (o_highest_written),
        .o_last             (o_last)
    );

    `WBRC_ASSERT(a_busy_after_accept, i_valid && !o_stall |=> o_stall, "no stall after accept")
    `WBRC_ASSERT(a_hit_not_wb, o_valid |-> !(o_hit && o_writeback_valid), "hit with writeback")
    `WBRC_ASSERT(a_one_emit, $countones({cmd.emit_read, cmd.emit_wb, cmd.emit_empty}) <= 1, "two emits")
    `WBRC_ASSERT_RST(a_reset_clears, !i_rst_n |=> !o_valid && !o_stall, "reset left state")
endmodule

// ===== src/wbrc_dp.sv =====
module wbrc_dp
    import wbrc_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int unsigned RECORD_BITS = RECORD_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    input  logic                   i_cfg_valid,
    input  logic [CAP_BITS-1:0]    i_cfg_data,
    input  logic [1:0]             i_kind,
    input  logic [KEY_BITS-1:0]    i_record_number,
    input  logic [RECORD_BITS-1:0] i_record_data,
    input  logic                   i_stall,
    output logic                   o_valid,
    output logic                   o_hit,
    output logic [RECORD_BITS-1:0] o_read_data,
    output logic                   o_writeback_valid,
    output logic [KEY_BITS-1:0]    o_writeback_number,
    output logic [RECORD_BITS-1:0] o_writeback_data,
    output logic [KEY_BITS-1:0]    o_highest_written,
    output logic                   o_last
);
    localparam int unsigned IW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CW    = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned CMP_W = ((CW > CAP_BITS) ? CW : CAP_BITS) + 1;

    logic [KEY_BITS-1:0]    r_key   [MAX_ENTRIES];
    logic [RECORD_BITS-1:0] r_data  [MAX_ENTRIES];
    logic                   r_dirty [MAX_ENTRIES];
    logic [CW-1:0]          r_count;
    logic [CAP_BITS-1:0]    r_cap;
    logic [KEY_BITS-1:0]    r_hw;
    t_kind                  r_kind;
    logic [KEY_BITS-1:0]    r_in_key;
    logic [RECORD_BITS-1:0] r_in_data;
    logic                   r_hit;
    logic [IW-1:0]          r_hit_idx;
    logic                   r_sent;

    logic                   r_o_valid;
    logic                   r_o_hit;
    logic [RECORD_BITS-1:0] r_o_rdata;
    logic                   r_o_wb;
    logic [KEY_BITS-1:0]    r_o_wnum;
    logic [RECORD_BITS-1:0] r_o_wdata;
    logic [KEY_BITS-1:0]    r_o_hw;
    logic                   r_o_last;

    logic [CMP_W-1:0] cap_ext, eff_cap, count_ext, lim;
    logic             need_evict, more_dirty, out_free, m_hit;
    logic [IW-1:0]    m_idx;

    always_comb begin
        cap_ext   = CMP_W'(r_cap);
        count_ext = CMP_W'(r_count);
        if (cap_ext < CMP_W'(CAP_MIN)) begin
            eff_cap = CMP_W'(CAP_MIN);
        end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
            eff_cap = CMP_W'(MAX_ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
        need_evict = (count_ext >= eff_cap);
        // Entries still to be written back after the head are indices 1..lim.
        lim = (r_kind == KIND_FLUSH) ? (count_ext - CMP_W'(1)) : (count_ext - eff_cap);
        more_dirty = 1'b0;
        for (int i = 1; i < MAX_ENTRIES; i++) begin
            if (r_dirty[i] && (CMP_W'(i) <= lim) && (CMP_W'(i) < count_ext)) begin
                more_dirty = 1'b1;
            end
        end
    end

    // Later matches override earlier ones, so the newest copy wins.
    always_comb begin
        m_hit = 1'b0;
        m_idx = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if ((CW'(i) < r_count) && (r_key[i] == r_in_key)) begin
                m_hit = 1'b1;
                m_idx = IW'(i);
            end
        end
    end

    assign out_free = !r_o_valid || !i_stall;

    always_comb begin
        o_sts.kind       = r_kind;
        o_sts.hit        = r_hit;
        o_sts.need_evict = need_evict;
        o_sts.head_dirty = r_dirty[0];
        o_sts.empty      = (r_count == '0);
        o_sts.sent       = r_sent;
        o_sts.out_free   = out_free;
    end

    for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_ent
        if (gi < MAX_ENTRIES - 1) begin : g_shift
            always_ff @(posedge i_clk) begin
                if (i_cmd.append && (CW'(gi) == r_count)) begin
                    r_key[gi]   <= r_in_key;
                    r_data[gi]  <= r_in_data;
                    r_dirty[gi] <= (r_kind == KIND_WRITE);
                end else if (i_cmd.drop_head || (i_cmd.drop_hit && (IW'(gi) >= r_hit_idx))) begin
                    r_key[gi]   <= r_key[gi+1];
                    r_data[gi]  <= r_data[gi+1];
                    r_dirty[gi] <= r_dirty[gi+1];
                end
            end
        end else begin : g_top
            always_ff @(posedge i_clk) begin
                if (i_cmd.append && (CW'(gi) == r_count)) begin
                    r_key[gi]   <= r_in_key;
                    r_data[gi]  <= r_in_data;
                    r_dirty[gi] <= (r_kind == KIND_WRITE);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind    <= t_kind'(i_kind);
            r_in_key  <= i_record_number;
            r_in_data <= i_record_data;
        end
        if (i_cmd.search) begin
            r_hit     <= m_hit;
            r_hit_idx <= m_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= CAP_BITS'(CAP_RESET);
            r_hw    <= '0;
            r_sent  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_sent <= 1'b0;
                if ((t_kind'(i_kind) == KIND_WRITE) && (i_record_number > r_hw)) begin
                    r_hw <= i_record_number;
                end
            end
            if (i_cmd.emit_wb) begin
                r_sent <= 1'b1;
            end
            if (i_cmd.drop_hit || i_cmd.drop_head) begin
                r_count <= r_count - CW'(1);
            end else if (i_cmd.append) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit_read || i_cmd.emit_wb || i_cmd.emit_empty) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_read || i_cmd.emit_wb || i_cmd.emit_empty) begin
            r_o_hw    <= r_hw;
            r_o_hit   <= i_cmd.emit_read && r_hit;
            r_o_rdata <= (i_cmd.emit_read && r_hit) ? r_data[r_hit_idx] : '0;
            r_o_wb    <= i_cmd.emit_wb;
            r_o_wnum  <= i_cmd.emit_wb ? r_key[0] : '0;
            r_o_wdata <= i_cmd.emit_wb ? r_data[0] : '0;
            r_o_last  <= i_cmd.emit_wb ? !more_dirty : 1'b1;
        end
    end

    assign o_valid            = r_o_valid;
    assign o_hit              = r_o_hit;
    assign o_read_data        = r_o_rdata;
    assign o_writeback_valid  = r_o_wb;
    assign o_writeback_number = r_o_wnum;
    assign o_writeback_data   = r_o_wdata;
    assign o_highest_written  = r_o_hw;
    assign o_last             = r_o_last;
endmodule

// ===== src/wbrc_ctrl.sv =====
module wbrc_ctrl
    import wbrc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_kind,
    output logic       o_stall,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    case (t_kind'(i_kind))
                        KIND_FILL:  n_state = ST_EVICT;
                        KIND_FLUSH: n_state = ST_FLUSH;
                        default:    n_state = ST_SEARCH;
                    endcase
                end
            end
            ST_SEARCH: begin
                n_state = (i_sts.kind == KIND_READ) ? ST_READOUT : ST_DROP;
            end
            ST_READOUT: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            ST_DROP:   n_state = ST_EVICT;
            ST_EVICT: begin
                if (!i_sts.need_evict) n_state = ST_APPEND;
            end
            ST_APPEND: n_state = i_sts.sent ? ST_IDLE : ST_EMPTY;
            ST_FLUSH: begin
                if (i_sts.empty) n_state = i_sts.sent ? ST_IDLE : ST_EMPTY;
            end
            ST_EMPTY: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE:    o_cmd.accept = i_valid;
            ST_SEARCH:  o_cmd.search = 1'b1;
            ST_READOUT: o_cmd.emit_read = i_sts.out_free;
            ST_DROP:    o_cmd.drop_hit = i_sts.hit;
            ST_EVICT, ST_FLUSH: begin
                // The head leaves unless a dirty head must wait for the output slot.
                if ((r_state == ST_EVICT) ? i_sts.need_evict : !i_sts.empty) begin
                    if (!i_sts.head_dirty) begin
                        o_cmd.drop_head = 1'b1;
                    end else if (i_sts.out_free) begin
                        o_cmd.drop_head = 1'b1;
                        o_cmd.emit_wb   = 1'b1;
                    end
                end
            end
            ST_APPEND:  o_cmd.append = 1'b1;
            ST_EMPTY:   o_cmd.emit_empty = i_sts.out_free;
            default:    o_cmd = '0;
        endcase
    end
endmodule

// ===== dv/write_back_record_cache_checker.sv =====
`timescale 1ns / 100ps

module write_back_record_cache_checker
    import wbrc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   o_stall,
    input  logic [1:0]             i_kind,
    input  logic [KEY_BITS-1:0]    i_record_number,
    input  logic [63:0]            i_record_data,
    input  logic                   o_valid,
    input  logic                   i_stall,
    input  logic                   o_hit,
    input  logic [63:0]            o_read_data,
    input  logic                   o_writeback_valid,
    input  logic [KEY_BITS-1:0]    o_writeback_number,
    input  logic [63:0]            o_writeback_data,
    input  logic [KEY_BITS-1:0]    o_highest_written,
    input  logic                   o_last,
    input  logic                   i_cfg_valid,
    input  logic                   o_cfg_ready,
    input  logic [CAP_BITS-1:0]    i_cfg_data,
    output int                     failures,
    output int                     pending
);
    typedef struct packed {
        logic        hit;
        logic [63:0] rdata;
        logic        wb_valid;
        logic [31:0] wb_number;
        logic [63:0] wb_data;
        logic [31:0] highest;
        logic        last;
    } t_result;

    t_result     expected_results[$];
    logic [31:0] line_key[MAX_ENTRIES_DEF];
    logic [63:0] line_data[MAX_ENTRIES_DEF];
    logic        line_dirty[MAX_ENTRIES_DEF];
    int          line_count;
    logic [31:0] top_key;
    logic [4:0]  cap_reg;

    assign pending = expected_results.size();

    function automatic void remove_line(int pos);
        for (int j = pos; j + 1 < line_count; j++) begin
            line_key[j]   = line_key[j + 1];
            line_data[j]  = line_data[j + 1];
            line_dirty[j] = line_dirty[j + 1];
        end
        line_count--;
    endfunction

    function automatic void predict_cache(t_kind kind, logic [31:0] key, logic [63:0] data);
        t_result r;
        t_result batch[$];
        int      cap;
        r = '0;
        case (kind)
            KIND_READ: begin
                for (int j = line_count - 1; j >= 0; j--) begin
                    if (line_key[j] == key) begin
                        r.hit   = 1'b1;
                        r.rdata = line_data[j];
                        break;
                    end
                end
                batch.push_back(r);
            end
            KIND_FLUSH: begin
                for (int j = 0; j < line_count; j++) begin
                    if (line_dirty[j]) begin
                        r = '0;
                        r.wb_valid = 1'b1;
                        r.wb_number = line_key[j];
                        r.wb_data = line_data[j];
                        batch.push_back(r);
                    end
                end
                line_count = 0;
            end
            default: begin
                if (kind == KIND_WRITE) begin
                    for (int j = line_count - 1; j >= 0; j--) begin
                        if (line_key[j] == key) begin
                            remove_line(j);
                            break;
                        end
                    end
                end
                cap = cap_reg < CAP_MIN ? CAP_MIN :
                      cap_reg > MAX_ENTRIES_DEF ? MAX_ENTRIES_DEF : cap_reg;
                while (line_count > 0 && line_count >= cap) begin
                    if (line_dirty[0]) begin
                        r = '0;
                        r.wb_valid = 1'b1;
                        r.wb_number = line_key[0];
                        r.wb_data = line_data[0];
                        batch.push_back(r);
                    end
                    remove_line(0);
                end
                line_key[line_count]   = key;
                line_data[line_count]  = data;
                line_dirty[line_count] = (kind == KIND_WRITE);
                line_count++;
                if (kind == KIND_WRITE && key > top_key) top_key = key;
            end
        endcase
        if (batch.size() == 0) batch.push_back('0);
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[j]) begin
            batch[j].highest = top_key;
            expected_results.push_back(batch[j]);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            line_count = 0;
            top_key = '0;
            cap_reg = CAP_RESET;
            failures = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) cap_reg = i_cfg_data;
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with no expectation waiting");
                    failures++;
                end else begin
                    e = expected_results.pop_front();
                    if (o_hit !== e.hit) begin
                        $error("hit: expected %0h, got %0h", e.hit, o_hit); failures++;
                    end
                    if (o_read_data !== e.rdata) begin
                        $error("read_data: expected %0h, got %0h", e.rdata, o_read_data);
                        failures++;
                    end
                    if (o_writeback_valid !== e.wb_valid) begin
                        $error("writeback_valid: expected %0h, got %0h", e.wb_valid,
                               o_writeback_valid);
                        failures++;
                    end
                    if (o_writeback_number !== e.wb_number) begin
                        $error("writeback_number: expected %0h, got %0h", e.wb_number,
                               o_writeback_number);
                        failures++;
                    end
                    if (o_writeback_data !== e.wb_data) begin
                        $error("writeback_data: expected %0h, got %0h", e.wb_data,
                               o_writeback_data);
                        failures++;
                    end
                    if (o_highest_written !== e.highest) begin
                        $error("highest_written: expected %0h, got %0h", e.highest,
                               o_highest_written);
                        failures++;
                    end
                    if (o_last !== e.last) begin
                        $error("last: expected %0h, got %0h", e.last, o_last); failures++;
                    end
                end
            end
            if (i_valid && !o_stall)
                predict_cache(t_kind'(i_kind), i_record_number, i_record_data);
        end
    end
endmodule

// ===== dv/write_back_record_cache_test.sv =====
`timescale 1ns / 100ps

module write_back_record_cache_test;
    import wbrc_pkg::*;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [1:0]          i_kind = KIND_READ;
    logic [KEY_BITS-1:0] i_record_number = '0;
    logic [63:0]         i_record_data = '0;
    logic                o_valid;
    logic                i_stall = 1'b1;
    logic                o_hit;
    logic [63:0]         o_read_data;
    logic                o_writeback_valid;
    logic [KEY_BITS-1:0] o_writeback_number;
    logic [63:0]         o_writeback_data;
    logic [KEY_BITS-1:0] o_highest_written;
    logic                o_last;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CAP_BITS-1:0] i_cfg_data = '0;
    int                  failures;
    int                  pending;
    bit                  drain_busy = 1'b1;

    always #6 i_clk = ~i_clk;

    write_back_record_cache dut (.*);

    write_back_record_cache_checker scoreboard (.*);

    // Keys come from a small pool so that hits, rewrites and evictions are common.
    logic [31:0] key_pool[8] = '{32'd1, 32'd2, 32'd3, 32'd0, 32'd7,
                                 32'hFFFF_FFFF, 32'h8000_0000, 32'h5A5A_A5A5};

    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    task automatic send_item(t_kind kind, logic [31:0] key, logic [63:0] data);
        repeat ($urandom_range(0, 14)) @(negedge i_clk);
        i_kind = kind;
        i_record_number = key;
        i_record_data = data;
        i_valid = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_capacity(logic [4:0] value);
        wait_drained();
        i_cfg_data = value;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic random_phase(int count);
        int     roll;
        t_kind  kind;
        logic [31:0] key;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            kind = roll < 35 ? KIND_READ : roll < 75 ? KIND_WRITE :
                   roll < 95 ? KIND_FILL : KIND_FLUSH;
            key = pick_key();
            send_item(kind, key, {$urandom, $urandom});
            // A read is followed by the matching fill half the time, at random.
            if (kind == KIND_READ && $urandom_range(0, 1))
                send_item(KIND_FILL, key, {$urandom, $urandom});
        end
    endtask

    // Result side stalls at random, with stretches of no stall.
    initial begin
        int gap;
        @(posedge i_rst_n);
        while (drain_busy) begin
            @(negedge i_clk);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
            if (gap != 0) begin
                i_stall = 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_stall = 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty cache, extremes, every kind.
        send_item(KIND_READ, 32'd1, '0);
        send_item(KIND_FLUSH, '0, '0);
        send_item(KIND_WRITE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(KIND_WRITE, 32'd0, 64'd0);
        send_item(KIND_READ, 32'd0, '0);
        send_item(KIND_READ, 32'hFFFF_FFFF, '0);
        send_item(KIND_READ, 32'd5, '0);
        send_item(KIND_FILL, 32'd5, 64'h0123_4567_89AB_CDEF);
        send_item(KIND_FILL, 32'd5, 64'hFEDC_BA98_7654_3210);
        send_item(KIND_READ, 32'd5, '0);
        send_item(KIND_WRITE, 32'hFFFF_FFFF, 64'h5555_5555_5555_5555);
        send_item(KIND_WRITE, 32'hAAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(KIND_FLUSH, '0, '0);
        send_item(KIND_READ, 32'd5, '0);

        write_capacity(5'd2);
        for (int n = 0; n < 5; n++) send_item(KIND_WRITE, 32'd10 + n, {$urandom, $urandom});
        write_capacity(5'd0);
        random_phase(40);
        write_capacity(5'd1);
        random_phase(20);
        write_capacity(5'd31);
        for (int n = 0; n < 17; n++) send_item(KIND_WRITE, 32'd100 + n, {$urandom, $urandom});
        // Shrinking below the fill level forces a burst of evictions.
        write_capacity(5'd3);
        send_item(KIND_FILL, 32'd7, '1);
        write_capacity(5'd16);
        random_phase(60);
        write_capacity(5'd5);
        random_phase(50);
        write_capacity(5'($urandom_range(2, 16)));
        random_phase(50);

        wait_drained();
        drain_busy = 1'b0;
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
